// File: rtl/lpcp_pkg.sv
package lpcp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DIV_N      = 48;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISTORTION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTRINSICS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_K3   = 3'd5;

	localparam logic signed [31:0] Q_ONE  = 32'sd65536;
	localparam logic signed [31:0] Q_HALF = 32'sd32768;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cam_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
		if (a > 64'(S32_MAX))
			sat32 = S32_MAX;
		else if (a < 64'(S32_MIN))
			sat32 = S32_MIN;
		else
			sat32 = a[31:0];
	endfunction

	// product back to q16.16, floor and clip
	function automatic logic signed [31:0] qfin(input logic signed [63:0] p);
		qfin = sat32(p >>> 16);
	endfunction

	function automatic logic signed [31:0] dbl(input logic signed [31:0] a);
		dbl = sat32(64'(a) + 64'(a));
	endfunction

	function automatic logic signed [31:0] add2(input logic signed [31:0] a,
		input logic signed [31:0] b);
		add2 = sat32(64'(a) + 64'(b));
	endfunction

	function automatic logic signed [31:0] add3(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic signed [31:0] c);
		add3 = sat32(64'(a) + 64'(b) + 64'(c));
	endfunction

endpackage

// File: rtl/lpcp_ifs.sv
interface lpcp_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpcp_pixel_if;
	logic               valid;
	logic               ready;
	logic        [15:0] pixel_column;
	logic        [15:0] pixel_row;
	logic signed [31:0] camera_x;
	logic signed [31:0] camera_y;
	logic signed [31:0] camera_z;
	modport source(output valid, pixel_column, pixel_row, camera_x, camera_y, camera_z,
		input ready);
	modport sink(input valid, pixel_column, pixel_row, camera_x, camera_y, camera_z,
		output ready);
endinterface

// File: rtl/lidar_point_camera_projector_top.sv
// channel   dir   handshake        payload
// points    in    valid / ready    point_x, point_y, point_z
// pixels    out   valid / ready    pixel_column, pixel_row, camera_x/y/z
// cfg       in    cfg_wen          cfg_index, cfg_data
//
// one point per clock while no held result stalls the pipeline; the divider yields one quotient bit per stage
// dropped points leave a bubble, no result
// arst_n clears all valid bits and loads the identity transform
// a held result freezes the whole pipeline; points.ready = !pixels.valid || pixels.ready
module lidar_point_camera_projector_top #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [lpcp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpcp_pkg::CFG_DATA_W-1:0]  cfg_data,
	lpcp_point_if.sink                       points,
	lpcp_pixel_if.source                     pixels
);

	localparam int DN = lpcp_pkg::DIV_N;
	localparam int T_SH = COORD_FRAC_BITS + 2;
	localparam logic signed [31:0] DEPTH_ONE = 32'sd1 <<< COORD_FRAC_BITS;

	// configuration
	logic [63:0] axis_x_q, axis_y_q, axis_z_q, dist_q, lens_q;
	logic [47:0] frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= 64'd16384;
			axis_y_q <= 64'd1073741824;
			axis_z_q <= 64'd70368744177664;
			dist_q   <= '0;
			lens_q   <= '0;
			frame_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				lpcp_pkg::REG_AXIS_X:     axis_x_q <= cfg_data;
				lpcp_pkg::REG_AXIS_Y:     axis_y_q <= cfg_data;
				lpcp_pkg::REG_AXIS_Z:     axis_z_q <= cfg_data;
				lpcp_pkg::REG_DISTORTION: dist_q   <= cfg_data;
				lpcp_pkg::REG_INTRINSICS: lens_q   <= cfg_data;
				lpcp_pkg::REG_FRAME_K3:   frame_q  <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] k1, k2, k3, p1, p2, fx, fy, cx, cy;
	logic [15:0] frm_w, frm_h;
	assign k1 = {{12{dist_q[15]}}, dist_q[15:0], 4'b0};
	assign k2 = {{12{dist_q[31]}}, dist_q[31:16], 4'b0};
	assign p1 = {{12{dist_q[47]}}, dist_q[47:32], 4'b0};
	assign p2 = {{12{dist_q[63]}}, dist_q[63:48], 4'b0};
	assign k3 = {{12{frame_q[47]}}, frame_q[47:32], 4'b0};
	assign fx = {4'b0, lens_q[15:0], 12'b0};
	assign fy = {4'b0, lens_q[31:16], 12'b0};
	assign cx = {4'b0, lens_q[47:32], 12'b0};
	assign cy = {4'b0, lens_q[63:48], 12'b0};
	assign frm_w = frame_q[15:0];
	assign frm_h = frame_q[31:16];

	logic adv;
	logic vld_s19;
	assign adv = !vld_s19 || pixels.ready;
	assign points.ready = adv;

	// s1: rotation products and translation terms
	logic [63:0] axis_w [3];
	logic signed [31:0] pt [3];
	assign axis_w[0] = axis_x_q;
	assign axis_w[1] = axis_y_q;
	assign axis_w[2] = axis_z_q;
	assign pt[0] = points.point_x;
	assign pt[1] = points.point_y;
	assign pt[2] = points.point_z;

	logic vld_s1, vld_s2;
	logic signed [47:0] prod_s1 [3][3];
	logic signed [51:0] tr_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				tr_s1[i] <= 52'($signed(axis_w[i][63:48])) <<< T_SH;
				for (int j = 0; j < 3; j++)
					prod_s1[i][j] <= 48'(pt[j]) * 48'($signed(axis_w[i][16*j +: 16]));
			end
		end
	end

	// s2: camera point
	logic signed [31:0] cam_nx [3];
	lpcp_pkg::cam_t cam_s2;
	always_comb begin
		for (int i = 0; i < 3; i++)
			cam_nx[i] = lpcp_pkg::sat32(64'((tr_s1[i] + 52'(prod_s1[i][0])
				+ 52'(prod_s1[i][1]) + 52'(prod_s1[i][2])) >>> 14));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cam_s2.x <= cam_nx[0];
			cam_s2.y <= cam_nx[1];
			cam_s2.z <= cam_nx[2];
		end
	end

	// divider, stage 0 is loaded from s2
	logic               dv_v_s   [DN+1];
	lpcp_pkg::cam_t     dv_cam_s [DN+1];
	logic               dv_sx_s  [DN+1];
	logic               dv_sy_s  [DN+1];
	logic [31:0]        dv_rx_s  [DN+1];
	logic [31:0]        dv_ry_s  [DN+1];
	logic [DN-1:0]      dv_nqx_s [DN+1];
	logic [DN-1:0]      dv_nqy_s [DN+1];

	logic [31:0] mag_x, mag_y;
	assign mag_x = cam_s2.x[31] ? 32'(-cam_s2.x) : cam_s2.x;
	assign mag_y = cam_s2.y[31] ? 32'(-cam_s2.y) : cam_s2.y;

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_cam_s[0] <= cam_s2;
			dv_sx_s[0]  <= cam_s2.x[31];
			dv_sy_s[0]  <= cam_s2.y[31];
			dv_rx_s[0]  <= '0;
			dv_ry_s[0]  <= '0;
			dv_nqx_s[0] <= {mag_x, 16'b0};
			dv_nqy_s[0] <= {mag_y, 16'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (adv)
			dv_v_s[0] <= vld_s2 && (cam_s2.z > DEPTH_ONE);
	end

	for (genvar k = 0; k < DN; k++) begin : g_div
		logic [31:0] dd;
		logic [32:0] tx, ty;
		logic gx, gy;
		assign dd = dv_cam_s[k].z;
		assign tx = {dv_rx_s[k], dv_nqx_s[k][DN-1]};
		assign ty = {dv_ry_s[k], dv_nqy_s[k][DN-1]};
		assign gx = tx >= {1'b0, dd};
		assign gy = ty >= {1'b0, dd};

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_cam_s[k+1] <= dv_cam_s[k];
				dv_sx_s[k+1]  <= dv_sx_s[k];
				dv_sy_s[k+1]  <= dv_sy_s[k];
				dv_rx_s[k+1]  <= gx ? 32'(tx - {1'b0, dd}) : tx[31:0];
				dv_ry_s[k+1]  <= gy ? 32'(ty - {1'b0, dd}) : ty[31:0];
				dv_nqx_s[k+1] <= {dv_nqx_s[k][DN-2:0], gx};
				dv_nqy_s[k+1] <= {dv_nqy_s[k][DN-2:0], gy};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[k+1] <= 1'b0;
			else if (adv)
				dv_v_s[k+1] <= dv_v_s[k];
		end
	end

	// s4: signed, clipped normalized coordinates
	logic [DN-1:0] qx, qy;
	logic signed [31:0] nx, ny;
	assign qx = dv_nqx_s[DN];
	assign qy = dv_nqy_s[DN];
	always_comb begin
		if (dv_sx_s[DN])
			nx = (qx > DN'(33'h80000000)) ? lpcp_pkg::S32_MIN : 32'(-qx[31:0]);
		else
			nx = (qx > DN'(32'h7fffffff)) ? lpcp_pkg::S32_MAX : qx[31:0];
		if (dv_sy_s[DN])
			ny = (qy > DN'(33'h80000000)) ? lpcp_pkg::S32_MIN : 32'(-qy[31:0]);
		else
			ny = (qy > DN'(32'h7fffffff)) ? lpcp_pkg::S32_MAX : qy[31:0];
	end

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic vld_s13, vld_s14, vld_s15, vld_s16, vld_s17, vld_s18;
	lpcp_pkg::cam_t cam_s4, cam_s5, cam_s6, cam_s7, cam_s8, cam_s9, cam_s10, cam_s11;
	lpcp_pkg::cam_t cam_s12, cam_s13, cam_s14, cam_s15, cam_s16, cam_s17, cam_s18, cam_s19;
	logic signed [31:0] x_s4, y_s4, x_s5, y_s5, x_s6, y_s6, x_s7, y_s7, x_s8, y_s8;
	logic signed [31:0] x_s9, y_s9, x_s10, y_s10, x_s11, y_s11, x_s12, y_s12, x_s13, y_s13;
	logic signed [63:0] pxx_s5, pyy_s5, pxy_s5;
	logic signed [31:0] qxx_s6, qyy_s6, qxy_s6, r2_s6;
	logic signed [63:0] pr4_s7, pk1_s7, pp1_s7, pp2_s7;
	logic signed [31:0] r2_s7, a_s7, b_s7;
	logic signed [31:0] r4_s8, k1r2_s8, t1_s8, t2_s8, r2_s8, a_s8, b_s8;
	logic signed [63:0] pr6_s9, pk2_s9;
	logic signed [31:0] k1r2_s9, t1_s9, t2_s9, a_s9, b_s9;
	logic signed [31:0] r6_s10, k2r4_s10, k1r2_s10, t1_s10, t2_s10, a_s10, b_s10;
	logic signed [63:0] pk3_s11;
	logic signed [31:0] k2r4_s11, k1r2_s11, t1_s11, t2_s11, a_s11, b_s11;
	logic signed [31:0] k3r6_s12, k2r4_s12, k1r2_s12, t1_s12, t2_s12, a_s12, b_s12;
	logic signed [31:0] d_s13, t1_s13, t2_s13, a_s13, b_s13;
	logic signed [63:0] pxd_s14, pyd_s14, ppa_s14, ppb_s14;
	logic signed [31:0] t1_s14, t2_s14;
	logic signed [31:0] qxd_s15, qyd_s15, qpa_s15, qpb_s15, t1_s15, t2_s15;
	logic signed [31:0] xd_s16, yd_s16;
	logic signed [63:0] pu_s17, pv_s17;
	logic signed [31:0] u_s18, v_s18;
	logic [15:0] col_s19, row_s19;

	// rounding and frame test
	logic signed [31:0] uh, vh;
	logic [15:0] col_nx, row_nx;
	logic in_frame;
	assign uh = lpcp_pkg::add2(u_s18, lpcp_pkg::Q_HALF);
	assign vh = lpcp_pkg::add2(v_s18, lpcp_pkg::Q_HALF);
	assign col_nx = uh[31] ? 16'd0 : uh[31:16];
	assign row_nx = vh[31] ? 16'd0 : vh[31:16];
	assign in_frame = (!uh[31] || uh > -32'sd65536) && (!vh[31] || vh > -32'sd65536)
		&& (col_nx < frm_w) && (row_nx < frm_h);

	always_ff @(posedge clk) begin
		if (adv) begin
			cam_s4 <= dv_cam_s[DN];
			x_s4 <= nx;
			y_s4 <= ny;

			cam_s5 <= cam_s4;
			pxx_s5 <= 64'(x_s4) * 64'(x_s4);
			pyy_s5 <= 64'(y_s4) * 64'(y_s4);
			pxy_s5 <= 64'(x_s4) * 64'(y_s4);
			x_s5 <= x_s4;
			y_s5 <= y_s4;

			cam_s6 <= cam_s5;
			qxx_s6 <= lpcp_pkg::qfin(pxx_s5);
			qyy_s6 <= lpcp_pkg::qfin(pyy_s5);
			qxy_s6 <= lpcp_pkg::qfin(pxy_s5);
			r2_s6 <= lpcp_pkg::add2(lpcp_pkg::qfin(pxx_s5), lpcp_pkg::qfin(pyy_s5));
			x_s6 <= x_s5;
			y_s6 <= y_s5;

			cam_s7 <= cam_s6;
			pr4_s7 <= 64'(r2_s6) * 64'(r2_s6);
			pk1_s7 <= 64'(k1) * 64'(r2_s6);
			pp1_s7 <= 64'(p1) * 64'(qxy_s6);
			pp2_s7 <= 64'(p2) * 64'(qxy_s6);
			a_s7 <= lpcp_pkg::add2(r2_s6, lpcp_pkg::dbl(qxx_s6));
			b_s7 <= lpcp_pkg::add2(r2_s6, lpcp_pkg::dbl(qyy_s6));
			r2_s7 <= r2_s6;
			x_s7 <= x_s6;
			y_s7 <= y_s6;

			cam_s8 <= cam_s7;
			r4_s8 <= lpcp_pkg::qfin(pr4_s7);
			k1r2_s8 <= lpcp_pkg::qfin(pk1_s7);
			t1_s8 <= lpcp_pkg::dbl(lpcp_pkg::qfin(pp1_s7));
			t2_s8 <= lpcp_pkg::dbl(lpcp_pkg::qfin(pp2_s7));
			r2_s8 <= r2_s7;
			a_s8 <= a_s7;
			b_s8 <= b_s7;
			x_s8 <= x_s7;
			y_s8 <= y_s7;

			cam_s9 <= cam_s8;
			pr6_s9 <= 64'(r4_s8) * 64'(r2_s8);
			pk2_s9 <= 64'(k2) * 64'(r4_s8);
			k1r2_s9 <= k1r2_s8;
			t1_s9 <= t1_s8;
			t2_s9 <= t2_s8;
			a_s9 <= a_s8;
			b_s9 <= b_s8;
			x_s9 <= x_s8;
			y_s9 <= y_s8;

			cam_s10 <= cam_s9;
			r6_s10 <= lpcp_pkg::qfin(pr6_s9);
			k2r4_s10 <= lpcp_pkg::qfin(pk2_s9);
			k1r2_s10 <= k1r2_s9;
			t1_s10 <= t1_s9;
			t2_s10 <= t2_s9;
			a_s10 <= a_s9;
			b_s10 <= b_s9;
			x_s10 <= x_s9;
			y_s10 <= y_s9;

			cam_s11 <= cam_s10;
			pk3_s11 <= 64'(k3) * 64'(r6_s10);
			k2r4_s11 <= k2r4_s10;
			k1r2_s11 <= k1r2_s10;
			t1_s11 <= t1_s10;
			t2_s11 <= t2_s10;
			a_s11 <= a_s10;
			b_s11 <= b_s10;
			x_s11 <= x_s10;
			y_s11 <= y_s10;

			cam_s12 <= cam_s11;
			k3r6_s12 <= lpcp_pkg::qfin(pk3_s11);
			k2r4_s12 <= k2r4_s11;
			k1r2_s12 <= k1r2_s11;
			t1_s12 <= t1_s11;
			t2_s12 <= t2_s11;
			a_s12 <= a_s11;
			b_s12 <= b_s11;
			x_s12 <= x_s11;
			y_s12 <= y_s11;

			// radial factor
			cam_s13 <= cam_s12;
			d_s13 <= lpcp_pkg::sat32(64'(lpcp_pkg::Q_ONE) + 64'(k1r2_s12)
				+ 64'(k2r4_s12) + 64'(k3r6_s12));
			t1_s13 <= t1_s12;
			t2_s13 <= t2_s12;
			a_s13 <= a_s12;
			b_s13 <= b_s12;
			x_s13 <= x_s12;
			y_s13 <= y_s12;

			cam_s14 <= cam_s13;
			pxd_s14 <= 64'(x_s13) * 64'(d_s13);
			pyd_s14 <= 64'(y_s13) * 64'(d_s13);
			ppa_s14 <= 64'(p2) * 64'(a_s13);
			ppb_s14 <= 64'(p1) * 64'(b_s13);
			t1_s14 <= t1_s13;
			t2_s14 <= t2_s13;

			cam_s15 <= cam_s14;
			qxd_s15 <= lpcp_pkg::qfin(pxd_s14);
			qyd_s15 <= lpcp_pkg::qfin(pyd_s14);
			qpa_s15 <= lpcp_pkg::qfin(ppa_s14);
			qpb_s15 <= lpcp_pkg::qfin(ppb_s14);
			t1_s15 <= t1_s14;
			t2_s15 <= t2_s14;

			cam_s16 <= cam_s15;
			xd_s16 <= lpcp_pkg::add3(qxd_s15, t1_s15, qpa_s15);
			yd_s16 <= lpcp_pkg::add3(qyd_s15, qpb_s15, t2_s15);

			cam_s17 <= cam_s16;
			pu_s17 <= 64'(fx) * 64'(xd_s16);
			pv_s17 <= 64'(fy) * 64'(yd_s16);

			cam_s18 <= cam_s17;
			u_s18 <= lpcp_pkg::add2(lpcp_pkg::qfin(pu_s17), cx);
			v_s18 <= lpcp_pkg::add2(lpcp_pkg::qfin(pv_s17), cy);

			cam_s19 <= cam_s18;
			col_s19 <= col_nx;
			row_s19 <= row_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
			vld_s19 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= points.valid;
			vld_s2 <= vld_s1;
			vld_s4 <= dv_v_s[DN];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
			vld_s18 <= vld_s17;
			vld_s19 <= vld_s18 && in_frame;
		end
	end

	assign pixels.valid        = vld_s19;
	assign pixels.pixel_column = col_s19;
	assign pixels.pixel_row    = row_s19;
	assign pixels.camera_x     = cam_s19.x;
	assign pixels.camera_y     = cam_s19.y;
	assign pixels.camera_z     = cam_s19.z;

	a_depth_drop: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s2 && (cam_s2.z <= DEPTH_ONE) |=> !dv_v_s[0])
		else $error("shallow point entered divider");

	a_quot_sign: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !cam_s4.x[31] |-> !x_s4[31])
		else $error("normalized x sign flipped");

	a_out_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid |-> cam_s19.z > DEPTH_ONE)
		else $error("result with depth at most one");

endmodule
